/* rtl/uos_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uos_pkg
// shared types, constants and helpers of the ultrasonic occupancy scanner
// ----------------------------------------------------------------------------
package uos_pkg;

    // sizing
    localparam int NUM_SENSORS = 4;
    localparam int DIST_BITS   = 16;
    localparam int SENSOR_W    = 4;
    localparam int SEL_W       = 2;
    localparam int TICK_W      = 24;
    localparam int PRE_W       = 8;
    localparam int CODE_W      = 2;
    localparam int DIST_OUT_W  = 16;
    localparam int THR_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // scan phases
    localparam logic [2:0] PH_WAIT      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_CHECK     = 3'd3;
    localparam logic [2:0] PH_RISE      = 3'd4;
    localparam logic [2:0] PH_MEASURE   = 3'd5;

    // sensor status codes
    localparam logic [CODE_W-1:0] CODE_FREE  = 2'd0;
    localparam logic [CODE_W-1:0] CODE_OCC   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_FAULT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_CM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;

    // register reset values
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 16'd20;
    localparam logic [TICK_W-1:0] RST_POLL      = 24'd5000000;
    localparam logic [PRE_W-1:0]  RST_TRIG_LOW  = 8'd4;
    localparam logic [PRE_W-1:0]  RST_TRIG_HIGH = 8'd10;
    localparam logic [PRE_W-1:0]  RST_TICKS_CM  = 8'd58;
    localparam logic [TICK_W-1:0] RST_TIMEOUT   = 24'd0;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
    localparam logic [TICK_W-1:0]    TICK_MAX = {TICK_W{1'b1}};

    typedef struct packed {
        logic [THR_W-1:0]  threshold_cm;
        logic [TICK_W-1:0] poll_interval_ticks;
        logic [PRE_W-1:0]  trigger_low_ticks;
        logic [PRE_W-1:0]  trigger_high_ticks;
        logic [PRE_W-1:0]  ticks_per_cm;
        logic [TICK_W-1:0] echo_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [SENSOR_W-1:0]             trigger_levels;
        logic                            distance_valid;
        logic [SEL_W-1:0]                measured_sensor;
        logic [DIST_OUT_W-1:0]           range_cm;
        logic                            report_valid;
        logic [SENSOR_W-1:0][CODE_W-1:0] codes;
    } t_result;

    // a zero count behaves as one
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

/* rtl/ultrasonic_occupancy_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_occupancy_scanner
// four-sensor ultrasonic ranger scanner with occupancy reporting
// ----------------------------------------------------------------------------
// Each input request is one microsecond tick carrying the four echo pin
// levels; each tick yields exactly one result request with the trigger pin
// drive, an optional finished distance and an optional occupancy report.
// Throughput is one tick per clock cycle unless stalled: the scan sequencer
// updates its state in the cycle the tick is accepted and the result lands
// in a single output register in the cycle after. The input side stalls
// only while that output register holds a result the consumer has not taken.
// Register writes through the cfg port take effect on the next tick.
// ----------------------------------------------------------------------------
module ultrasonic_occupancy_scanner (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    // configuration write port
    input  wire                                i_cfg_wr_en,
    input  wire  [uos_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [uos_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // tick input channel
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [uos_pkg::SENSOR_W-1:0]       i_echo_levels,

    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [uos_pkg::SENSOR_W-1:0]       o_trigger_levels,
    output logic                               o_distance_valid,
    output logic [uos_pkg::SEL_W-1:0]          o_measured_sensor,
    output logic [uos_pkg::DIST_OUT_W-1:0]     o_range_cm,
    output logic                               o_report_valid,
    output logic [uos_pkg::CODE_W-1:0]         o_code_sensor0,
    output logic [uos_pkg::CODE_W-1:0]         o_code_sensor1,
    output logic [uos_pkg::CODE_W-1:0]         o_code_sensor2,
    output logic [uos_pkg::CODE_W-1:0]         o_code_sensor3
);

    uos_pkg::t_cfg    cfg;
    uos_pkg::t_result core_result;
    uos_pkg::t_result out_result;
    logic             can_load;
    logic             step;

    // a tick is taken whenever the result register is free or draining
    assign o_in_ready = can_load;
    assign step       = i_in_valid && can_load;

    uos_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: wait, trigger low, trigger high, check, rise, measure
    uos_scan_core u_scan_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_echo_levels (i_echo_levels),
        .i_cfg         (cfg),
        .o_result      (core_result)
    );

    // result register parts the tick side from the consumer
    uos_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_result    (core_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_can_load  (can_load),
        .o_result    (out_result)
    );

    // unpack result fields onto their own ports
    assign o_trigger_levels  = out_result.trigger_levels;
    assign o_distance_valid  = out_result.distance_valid;
    assign o_measured_sensor = out_result.measured_sensor;
    assign o_range_cm        = out_result.range_cm;
    assign o_report_valid    = out_result.report_valid;
    assign o_code_sensor0    = out_result.codes[0];
    assign o_code_sensor1    = out_result.codes[1];
    assign o_code_sensor2    = out_result.codes[2];
    assign o_code_sensor3    = out_result.codes[3];

endmodule
`default_nettype wire

/* rtl/uos_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uos_cfg_regs
// configuration register bank, written through a plain write port
// ----------------------------------------------------------------------------
module uos_cfg_regs (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_wr_en,
    input  wire  [uos_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [uos_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output uos_pkg::t_cfg                     o_cfg
);

    uos_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_cm        <= uos_pkg::RST_THRESHOLD;
            r_cfg.poll_interval_ticks <= uos_pkg::RST_POLL;
            r_cfg.trigger_low_ticks   <= uos_pkg::RST_TRIG_LOW;
            r_cfg.trigger_high_ticks  <= uos_pkg::RST_TRIG_HIGH;
            r_cfg.ticks_per_cm        <= uos_pkg::RST_TICKS_CM;
            r_cfg.echo_timeout_ticks  <= uos_pkg::RST_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                uos_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold_cm <= i_cfg_data[uos_pkg::THR_W-1:0];
                end
                uos_pkg::CFG_POLL: begin
                    r_cfg.poll_interval_ticks <= i_cfg_data[uos_pkg::TICK_W-1:0];
                end
                uos_pkg::CFG_TRIG_LOW: begin
                    r_cfg.trigger_low_ticks <= i_cfg_data[uos_pkg::PRE_W-1:0];
                end
                uos_pkg::CFG_TRIG_HIGH: begin
                    r_cfg.trigger_high_ticks <= i_cfg_data[uos_pkg::PRE_W-1:0];
                end
                uos_pkg::CFG_TICKS_CM: begin
                    r_cfg.ticks_per_cm <= i_cfg_data[uos_pkg::PRE_W-1:0];
                end
                uos_pkg::CFG_TIMEOUT: begin
                    r_cfg.echo_timeout_ticks <= i_cfg_data[uos_pkg::TICK_W-1:0];
                end
                default: begin
                    // unknown index, ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* rtl/uos_scan_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uos_scan_core
// per-tick scan sequencer: trigger timing, echo measurement, classification
// ----------------------------------------------------------------------------
module uos_scan_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_step,
    input  wire  [uos_pkg::SENSOR_W-1:0]      i_echo_levels,
    input  uos_pkg::t_cfg                     i_cfg,
    output uos_pkg::t_result                  o_result
);

    localparam int LAST_W = uos_pkg::SEL_W + 1;

    logic [2:0]                                        r_phase, n_phase;
    logic [uos_pkg::SEL_W-1:0]                         r_sel, n_sel;
    logic [uos_pkg::TICK_W-1:0]                        r_tick, n_tick;
    logic [uos_pkg::PRE_W-1:0]                         r_prescale, n_prescale;
    logic [uos_pkg::DIST_BITS-1:0]                     r_dist, n_dist;
    logic [uos_pkg::SENSOR_W-1:0][uos_pkg::CODE_W-1:0] r_new_codes, n_new_codes;
    logic [uos_pkg::SENSOR_W-1:0][uos_pkg::CODE_W-1:0] r_old_codes, n_old_codes;
    logic                                              r_first, n_first;

    logic                          echo;
    logic [uos_pkg::TICK_W-1:0]    tick_inc;
    logic [uos_pkg::TICK_W-1:0]    tick_sat;
    logic [uos_pkg::TICK_W-1:0]    tpc_min;
    logic                          fin;
    logic [uos_pkg::CODE_W-1:0]    fin_code;
    logic                          last_sensor;
    logic                          changed;
    uos_pkg::t_result              res;

    assign echo     = i_echo_levels[r_sel];
    assign tick_inc = r_tick + uos_pkg::TICK_W'(1);
    assign tick_sat = (r_tick < uos_pkg::TICK_MAX) ? tick_inc : r_tick;
    assign tpc_min  = uos_pkg::at_least_one(uos_pkg::TICK_W'(i_cfg.ticks_per_cm));
    assign last_sensor = (LAST_W'(r_sel) + LAST_W'(1)) >= LAST_W'(uos_pkg::NUM_SENSORS);

    always_comb begin
        n_phase     = r_phase;
        n_sel       = r_sel;
        n_tick      = r_tick;
        n_prescale  = r_prescale;
        n_dist      = r_dist;
        n_new_codes = r_new_codes;
        n_old_codes = r_old_codes;
        n_first     = r_first;
        fin         = 1'b0;
        fin_code    = uos_pkg::CODE_FAULT;
        changed     = 1'b0;
        res         = '0;

        case (r_phase)
            uos_pkg::PH_TRIG_LOW: begin
                n_tick = tick_inc;
                if (tick_inc >= uos_pkg::at_least_one(
                        uos_pkg::TICK_W'(i_cfg.trigger_low_ticks))) begin
                    n_tick  = '0;
                    n_phase = uos_pkg::PH_TRIG_HIGH;
                end
            end
            uos_pkg::PH_TRIG_HIGH: begin
                res.trigger_levels = uos_pkg::SENSOR_W'(1) << r_sel;
                n_tick = tick_inc;
                if (tick_inc >= uos_pkg::at_least_one(
                        uos_pkg::TICK_W'(i_cfg.trigger_high_ticks))) begin
                    n_tick  = '0;
                    n_phase = uos_pkg::PH_CHECK;
                end
            end
            uos_pkg::PH_CHECK: begin
                if (echo) begin
                    fin = 1'b1;
                end else begin
                    n_tick  = '0;
                    n_phase = uos_pkg::PH_RISE;
                end
            end
            uos_pkg::PH_RISE, uos_pkg::PH_MEASURE: begin
                n_tick = tick_sat;
                if ((i_cfg.echo_timeout_ticks != '0) &&
                    (tick_sat > i_cfg.echo_timeout_ticks)) begin
                    fin = 1'b1;
                end else if (r_phase == uos_pkg::PH_RISE) begin
                    if (echo) begin
                        // first echo tick counts from a cleared prescaler
                        n_phase = uos_pkg::PH_MEASURE;
                        if (uos_pkg::TICK_W'(1) >= tpc_min) begin
                            n_prescale = '0;
                            n_dist     = uos_pkg::DIST_BITS'(1);
                        end else begin
                            n_prescale = uos_pkg::PRE_W'(1);
                            n_dist     = '0;
                        end
                    end
                end else if (echo) begin
                    n_prescale = r_prescale + uos_pkg::PRE_W'(1);
                    if (uos_pkg::TICK_W'(n_prescale) >= tpc_min) begin
                        n_prescale = '0;
                        if (r_dist < uos_pkg::DIST_MAX) begin
                            n_dist = r_dist + uos_pkg::DIST_BITS'(1);
                        end
                    end
                end else begin
                    res.distance_valid  = 1'b1;
                    res.measured_sensor = r_sel;
                    res.range_cm        = uos_pkg::DIST_OUT_W'(r_dist);
                    fin      = 1'b1;
                    fin_code = (uos_pkg::THR_W'(r_dist) <= i_cfg.threshold_cm) ?
                               uos_pkg::CODE_OCC : uos_pkg::CODE_FREE;
                end
            end
            default: begin
                n_phase = uos_pkg::PH_WAIT;
                n_tick  = tick_inc;
                if (tick_inc >= uos_pkg::at_least_one(i_cfg.poll_interval_ticks)) begin
                    n_tick  = '0;
                    n_sel   = '0;
                    n_phase = uos_pkg::PH_TRIG_LOW;
                end
            end
        endcase

        // sensor done: record code, advance or close the scan
        if (fin) begin
            n_new_codes[r_sel] = fin_code;
            n_tick = '0;
            if (last_sensor) begin
                for (int i = 0; i < uos_pkg::NUM_SENSORS; i++) begin
                    if (n_new_codes[i] != r_old_codes[i]) begin
                        changed = 1'b1;
                    end
                end
                n_old_codes = n_new_codes;
                n_first     = 1'b0;
                n_sel       = '0;
                n_phase     = uos_pkg::PH_WAIT;
                res.report_valid = changed || r_first;
                if (changed || r_first) begin
                    for (int i = 0; i < uos_pkg::NUM_SENSORS; i++) begin
                        res.codes[i] = n_new_codes[i];
                    end
                end
            end else begin
                n_sel   = r_sel + uos_pkg::SEL_W'(1);
                n_phase = uos_pkg::PH_TRIG_LOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uos_pkg::PH_WAIT;
            r_sel       <= '0;
            r_tick      <= '0;
            r_prescale  <= '0;
            r_dist      <= '0;
            r_new_codes <= '0;
            r_old_codes <= '0;
            r_first     <= 1'b1;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_sel       <= n_sel;
            r_tick      <= n_tick;
            r_prescale  <= n_prescale;
            r_dist      <= n_dist;
            r_new_codes <= n_new_codes;
            r_old_codes <= n_old_codes;
            r_first     <= n_first;
        end
    end

    assign o_result = res;

endmodule
`default_nettype wire

/* rtl/uos_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uos_out_reg
// result register with valid/ready, accepts a new result while one is taken
// ----------------------------------------------------------------------------
module uos_out_reg (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  uos_pkg::t_result       i_result,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_can_load,
    output uos_pkg::t_result       o_result
);

    logic             r_valid;
    uos_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

/* dv/uos_occupancy_checker.sv */
// ----------------------------------------------------------------------------
// uos_occupancy_checker
// watches the tick and result channels of the occupancy scanner, predicts
// every result from its own copy of the scan sequencer and compares field
// by field against the oldest prediction still waiting
// ----------------------------------------------------------------------------
module uos_occupancy_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire  [uos_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [uos_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                             i_in_valid,
    input  wire                             i_in_ready,
    input  wire  [uos_pkg::SENSOR_W-1:0]    i_echo_levels,
    input  wire                             i_out_valid,
    input  wire                             i_out_ready,
    input  wire  [uos_pkg::SENSOR_W-1:0]    i_trigger_levels,
    input  wire                             i_distance_valid,
    input  wire  [uos_pkg::SEL_W-1:0]       i_measured_sensor,
    input  wire  [uos_pkg::DIST_OUT_W-1:0]  i_range_cm,
    input  wire                             i_report_valid,
    input  wire  [uos_pkg::CODE_W-1:0]      i_code_sensor0,
    input  wire  [uos_pkg::CODE_W-1:0]      i_code_sensor1,
    input  wire  [uos_pkg::CODE_W-1:0]      i_code_sensor2,
    input  wire  [uos_pkg::CODE_W-1:0]      i_code_sensor3,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import uos_pkg::*;

    // register copy and scan state
    t_cfg                   regs;
    logic [2:0]             scan_phase;
    logic [SEL_W-1:0]       cur_sensor;
    logic [TICK_W-1:0]      phase_ticks;
    logic [PRE_W-1:0]       cm_ticks;
    logic [DIST_BITS-1:0]   dist_acc;
    logic [CODE_W-1:0]      pending_codes [NUM_SENSORS];
    logic [CODE_W-1:0]      last_codes [NUM_SENSORS];
    logic                   first_pass;

    t_result                tick_results_q [$];
    int                     mismatches = 0;
    int                     results_seen = 0;

    assign o_mismatches = mismatches;
    initial o_outstanding = 0;

    task automatic flag(input string field, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                 $time, results_seen, field, got, want);
    endtask

    // a programmed count of zero behaves as one
    function automatic logic [TICK_W-1:0] count_limit(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    task automatic count_cm();
        cm_ticks = cm_ticks + PRE_W'(1);
        if (TICK_W'(cm_ticks) >= count_limit(TICK_W'(regs.ticks_per_cm))) begin
            cm_ticks = '0;
            if (dist_acc != DIST_MAX)
                dist_acc = dist_acc + DIST_BITS'(1);
        end
    endtask

    task automatic close_sensor(input logic [CODE_W-1:0] code, output logic emit);
        emit = 1'b0;
        pending_codes[cur_sensor] = code;
        phase_ticks = '0;
        if (int'(cur_sensor) + 1 >= NUM_SENSORS) begin
            for (int i = 0; i < NUM_SENSORS; i++)
                if (pending_codes[i] != last_codes[i])
                    emit = 1'b1;
            if (first_pass)
                emit = 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++)
                last_codes[i] = pending_codes[i];
            first_pass = 1'b0;
            cur_sensor = '0;
            scan_phase = PH_WAIT;
        end else begin
            cur_sensor = cur_sensor + SEL_W'(1);
            scan_phase = PH_TRIG_LOW;
        end
    endtask

    task automatic advance_scan(input logic [SENSOR_W-1:0] echo_bits, output t_result res);
        logic [SEL_W-1:0] s;
        logic             echo;
        logic             emit;
        s    = cur_sensor;
        echo = echo_bits[s];
        emit = 1'b0;
        res  = '0;
        case (scan_phase)
            PH_TRIG_LOW: begin
                phase_ticks = phase_ticks + TICK_W'(1);
                if (phase_ticks >= count_limit(TICK_W'(regs.trigger_low_ticks))) begin
                    phase_ticks = '0;
                    scan_phase  = PH_TRIG_HIGH;
                end
            end
            PH_TRIG_HIGH: begin
                res.trigger_levels[s] = 1'b1;
                phase_ticks = phase_ticks + TICK_W'(1);
                if (phase_ticks >= count_limit(TICK_W'(regs.trigger_high_ticks))) begin
                    phase_ticks = '0;
                    scan_phase  = PH_CHECK;
                end
            end
            PH_CHECK: begin
                // echo already up right after the pulse means a stuck sensor
                if (echo) begin
                    close_sensor(CODE_FAULT, emit);
                end else begin
                    phase_ticks = '0;
                    scan_phase  = PH_RISE;
                end
            end
            PH_RISE, PH_MEASURE: begin
                if (phase_ticks != TICK_MAX)
                    phase_ticks = phase_ticks + TICK_W'(1);
                if (regs.echo_timeout_ticks != '0 && phase_ticks > regs.echo_timeout_ticks) begin
                    close_sensor(CODE_FAULT, emit);
                end else if (scan_phase == PH_RISE) begin
                    if (echo) begin
                        cm_ticks = '0;
                        dist_acc = '0;
                        count_cm();
                        scan_phase = PH_MEASURE;
                    end
                end else if (echo) begin
                    count_cm();
                end else begin
                    res.distance_valid  = 1'b1;
                    res.measured_sensor = s;
                    res.range_cm        = DIST_OUT_W'(dist_acc);
                    close_sensor((dist_acc <= regs.threshold_cm) ? CODE_OCC : CODE_FREE, emit);
                end
            end
            default: begin
                scan_phase  = PH_WAIT;
                phase_ticks = phase_ticks + TICK_W'(1);
                if (phase_ticks >= count_limit(regs.poll_interval_ticks)) begin
                    phase_ticks = '0;
                    cur_sensor  = '0;
                    scan_phase  = PH_TRIG_LOW;
                end
            end
        endcase
        if (emit) begin
            res.report_valid = 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++)
                res.codes[i] = last_codes[i];
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result                         want;
        t_result                         fresh;
        logic [SENSOR_W-1:0][CODE_W-1:0] got_codes;
        if (!i_rst_n) begin
            regs.threshold_cm        = RST_THRESHOLD;
            regs.poll_interval_ticks = RST_POLL;
            regs.trigger_low_ticks   = RST_TRIG_LOW;
            regs.trigger_high_ticks  = RST_TRIG_HIGH;
            regs.ticks_per_cm        = RST_TICKS_CM;
            regs.echo_timeout_ticks  = RST_TIMEOUT;
            scan_phase  = PH_WAIT;
            cur_sensor  = '0;
            phase_ticks = '0;
            cm_ticks    = '0;
            dist_acc    = '0;
            first_pass  = 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                pending_codes[i] = CODE_FREE;
                last_codes[i]    = CODE_FREE;
            end
            tick_results_q.delete();
        end else begin
            // results first: a result can never belong to a tick taken at this edge
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (tick_results_q.size() == 0) begin
                    flag("result with no tick outstanding", 1, 0);
                end else begin
                    want      = tick_results_q.pop_front();
                    got_codes = {i_code_sensor3, i_code_sensor2, i_code_sensor1, i_code_sensor0};
                    if (i_trigger_levels !== want.trigger_levels)
                        flag("trigger_levels", 32'(i_trigger_levels),
                             32'(want.trigger_levels));
                    if (i_distance_valid !== want.distance_valid)
                        flag("distance_valid", 32'(i_distance_valid),
                             32'(want.distance_valid));
                    if (i_measured_sensor !== want.measured_sensor)
                        flag("measured_sensor", 32'(i_measured_sensor),
                             32'(want.measured_sensor));
                    if (i_range_cm !== want.range_cm)
                        flag("range_cm", 32'(i_range_cm), 32'(want.range_cm));
                    if (i_report_valid !== want.report_valid)
                        flag("report_valid", 32'(i_report_valid), 32'(want.report_valid));
                    for (int i = 0; i < SENSOR_W; i++)
                        if (got_codes[i] !== want.codes[i])
                            flag($sformatf("code_sensor%0d", i), 32'(got_codes[i]),
                                 32'(want.codes[i]));
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_scan(i_echo_levels, fresh);
                tick_results_q.push_back(fresh);
            end
            // register writes count from the next tick on
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: regs.threshold_cm        = i_cfg_data[THR_W-1:0];
                    CFG_POLL:      regs.poll_interval_ticks = i_cfg_data[TICK_W-1:0];
                    CFG_TRIG_LOW:  regs.trigger_low_ticks   = i_cfg_data[PRE_W-1:0];
                    CFG_TRIG_HIGH: regs.trigger_high_ticks  = i_cfg_data[PRE_W-1:0];
                    CFG_TICKS_CM:  regs.ticks_per_cm        = i_cfg_data[PRE_W-1:0];
                    CFG_TIMEOUT:   regs.echo_timeout_ticks  = i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding <= tick_results_q.size();
    end

endmodule

/* dv/tb_ultrasonic_occupancy_scanner.sv */
// ----------------------------------------------------------------------------
// tb_ultrasonic_occupancy_scanner
// drives echo ticks and register settings into the occupancy scanner, with
// random gaps on the tick side and random stalls on the result side; the
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_ultrasonic_occupancy_scanner;
    import uos_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 17;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 170;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // opening echo script, first tick in the top nibble; with the poll, trigger
    // and prescale counts at zero it gives a stuck echo on sensor 0, a short echo
    // on sensor 1, an echo timeout on sensor 2 and a one centimetre echo on sensor 3
    localparam int             OPENING_LEN  = 24;
    localparam logic [95:0]    OPENING_ECHO = 96'h0F0F5A02_20F00000_00008000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [SENSOR_W-1:0]    echo_levels;
    logic                   out_valid;
    logic                   out_ready;
    logic [SENSOR_W-1:0]    trigger_levels;
    logic                   distance_valid;
    logic [SEL_W-1:0]       measured_sensor;
    logic [DIST_OUT_W-1:0]  range_cm;
    logic                   report_valid;
    logic [CODE_W-1:0]      code_sensor0;
    logic [CODE_W-1:0]      code_sensor1;
    logic [CODE_W-1:0]      code_sensor2;
    logic [CODE_W-1:0]      code_sensor3;

    int                     mismatches;
    int                     outstanding;
    int                     cycle_count = 0;

    // per-sensor echo pulse trains
    logic [SENSOR_W-1:0]    pulse_level;
    int                     pulse_hold [SENSOR_W];
    int                     pulse_max;

    ultrasonic_occupancy_scanner dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_echo_levels     (echo_levels),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_trigger_levels  (trigger_levels),
        .o_distance_valid  (distance_valid),
        .o_measured_sensor (measured_sensor),
        .o_range_cm        (range_cm),
        .o_report_valid    (report_valid),
        .o_code_sensor0    (code_sensor0),
        .o_code_sensor1    (code_sensor1),
        .o_code_sensor2    (code_sensor2),
        .o_code_sensor3    (code_sensor3)
    );

    uos_occupancy_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_echo_levels     (echo_levels),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_trigger_levels  (trigger_levels),
        .i_distance_valid  (distance_valid),
        .i_measured_sensor (measured_sensor),
        .i_range_cm        (range_cm),
        .i_report_valid    (report_valid),
        .i_code_sensor0    (code_sensor0),
        .i_code_sensor1    (code_sensor1),
        .i_code_sensor2    (code_sensor2),
        .i_code_sensor3    (code_sensor3),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    // 12 unit clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog, generous against the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: a fresh stall draw for every result request
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // one register write, enable left high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // full register set, only called with no result outstanding
    task automatic write_settings(input logic [THR_W-1:0] thr, input logic [TICK_W-1:0] poll,
                                  input logic [PRE_W-1:0] trig_lo, input logic [PRE_W-1:0] trig_hi,
                                  input logic [PRE_W-1:0] per_cm, input logic [TICK_W-1:0] tmo);
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_POLL,      poll);
        write_reg(CFG_TRIG_LOW,  CFG_DATA_W'(trig_lo));
        write_reg(CFG_TRIG_HIGH, CFG_DATA_W'(trig_hi));
        write_reg(CFG_TICKS_CM,  CFG_DATA_W'(per_cm));
        write_reg(CFG_TIMEOUT,   tmo);
        cfg_wr_en <= 1'b0;
    endtask

    // one tick request: optional gap, then hold until taken
    task automatic send_tick(input logic [SENSOR_W-1:0] bits);
        int gap;
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        echo_levels <= bits;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic send_level(input logic [SENSOR_W-1:0] bits, input int count);
        repeat (count) send_tick(bits);
    endtask

    // drop valid and wait until every tick has its result back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // next echo sample: independent pulse trains, lows about three times
    // longer than highs so most checks see a quiet line, plus rare glitches
    task automatic draw_echo(output logic [SENSOR_W-1:0] bits);
        int flip;
        for (int i = 0; i < SENSOR_W; i++) begin
            if (pulse_hold[i] == 0) begin
                pulse_level[i] = ~pulse_level[i];
                pulse_hold[i]  = pulse_level[i] ? $urandom_range(1, pulse_max)
                                                : $urandom_range(1, 3 * pulse_max);
            end
            pulse_hold[i]--;
        end
        bits = pulse_level;
        if ($urandom_range(0, 19) == 0) begin
            flip = $urandom_range(0, SENSOR_W - 1);
            bits[flip] = ~bits[flip];
        end
    endtask

    task automatic send_random(input int count);
        logic [SENSOR_W-1:0] bits;
        repeat (count) begin
            draw_echo(bits);
            send_tick(bits);
        end
    endtask

    // short counts so scans finish quickly; thresholds near the likely
    // distances, with the range ends and zero counts mixed in
    task automatic pick_settings();
        logic [THR_W-1:0]  thr;
        logic [PRE_W-1:0]  per_cm;
        logic [TICK_W-1:0] tmo;
        pulse_max = $urandom_range(3, 40);
        per_cm = ($urandom_range(0, 9) == 0) ? '0 : PRE_W'($urandom_range(1, 6));
        case ($urandom_range(0, 7))
            0:       thr = '0;
            1:       thr = '1;
            default: thr = THR_W'($urandom_range(0, pulse_max / 2 + 2));
        endcase
        tmo = ($urandom_range(0, 1) == 0) ? '0 : TICK_W'($urandom_range(2, 4 * pulse_max));
        write_settings(thr, TICK_W'($urandom_range(0, 40)), PRE_W'($urandom_range(0, 6)),
                       PRE_W'($urandom_range(0, 6)), per_cm, tmo);
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        echo_levels = '0;
        pulse_level = '0;
        pulse_max   = 8;
        for (int i = 0; i < SENSOR_W; i++)
            pulse_hold[i] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // opening script: zero counts, short timeout, writes past the list
        write_reg(CFG_UNUSED_LO, '1);
        write_reg(CFG_UNUSED_HI, 24'h5A5A5A);
        write_settings(16'd1, '0, '0, '0, '0, 24'd3);
        for (int k = 0; k < OPENING_LEN; k++)
            send_tick(OPENING_ECHO[(OPENING_LEN - 1 - k) * 4 +: 4]);
        settle();

        // longest poll wait: the scan in flight ends, then nothing starts
        write_settings('1, TICK_MAX, 8'd1, 8'd1, 8'd1, '0);
        send_random(60);
        settle();

        // random settings, a fresh set per phase
        for (int p = 0; p < PHASES; p++) begin
            pick_settings();
            send_random(PHASE_TICKS);
            settle();
        end

        // slowest prescale and the longest timeout
        pulse_max = 60;
        write_settings('0, 24'd1, 8'd1, 8'd1, '1, TICK_MAX);
        send_random(200);
        settle();

        // flush any scan in flight into the poll wait with a tight timeout
        write_settings('1, TICK_MAX, 8'd1, 8'd1, 8'd1, 24'd2);
        send_level('0, 40);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
